// ===== rtl/rpo_pkg.sv =====
// ----------------------------------------------------------------------------
// rpo_pkg: shared types and constants for the RGB pixel point operations
// Holds the pixel and configuration types, the operation and register codes,
// the reset values of the registers and the grayscale mean helper.
// ----------------------------------------------------------------------------
package rpo_pkg;

    localparam int RPO_CHAN_W                = 8;
    localparam int RPO_GAIN_W                = 16;
    localparam int RPO_CFG_DATA_W            = 16;
    localparam int RPO_CFG_INDEX_W           = 3;
    localparam int RPO_GAIN_FRAC_BITS_DEFAULT = 8;

    localparam logic [RPO_CHAN_W-1:0] RPO_CHAN_MAX = 8'd255;
    localparam logic [RPO_CHAN_W-1:0] RPO_MID_GRAY = 8'd128;

    // Reset gain of 1.0 for the default fixed-point format.
    localparam logic [RPO_GAIN_W-1:0] RPO_GAIN_RESET = 16'd256;

    typedef enum logic [1:0] {
        OP_GRAY     = 2'd0,
        OP_TINT     = 2'd1,
        OP_CONTRAST = 2'd2,
        OP_NEGATIVE = 2'd3
    } op_mode_t;

    typedef enum logic [RPO_CFG_INDEX_W-1:0] {
        CFG_OP_MODE         = 3'd0,
        CFG_GAIN_RED        = 3'd1,
        CFG_GAIN_GREEN      = 3'd2,
        CFG_GAIN_BLUE       = 3'd3,
        CFG_CONTRAST_FACTOR = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [RPO_CHAN_W-1:0] red;
        logic [RPO_CHAN_W-1:0] green;
        logic [RPO_CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        op_mode_t              op_mode;
        logic [RPO_GAIN_W-1:0] gain_red;
        logic [RPO_GAIN_W-1:0] gain_green;
        logic [RPO_GAIN_W-1:0] gain_blue;
        logic [RPO_GAIN_W-1:0] contrast_factor;
    } cfg_t;

    // Division by three of a sum of three channels (at most 765) done as a
    // multiplication by 683/2048. The error stays below 1/8, so the floor is
    // exact over the whole range.
    localparam logic [10:0] RPO_RECIP3      = 11'd683;
    localparam int          RPO_RECIP3_SHIFT = 11;

    function automatic logic [RPO_CHAN_W-1:0] gray_mean(input logic [9:0] sum);
        logic [20:0] prod;
        begin
            prod = {11'd0, sum} * {10'd0, RPO_RECIP3};
            gray_mean = prod[RPO_RECIP3_SHIFT +: RPO_CHAN_W];
        end
    endfunction

endpackage

// ===== rtl/rpo_in_if.sv =====
// ----------------------------------------------------------------------------
// rpo_in_if: input pixel channel
// Valid/ready channel that carries one input RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface rpo_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

// ===== rtl/rpo_out_if.sv =====
// ----------------------------------------------------------------------------
// rpo_out_if: result pixel channel
// Valid/ready channel that carries one processed RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface rpo_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    output ready);
endinterface

// ===== rtl/rgb_pixel_point_ops.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_point_ops: point operations on an RGB pixel stream
// Top level: input register, pixel arithmetic, result register, config port.
// ----------------------------------------------------------------------------
// The block takes one 8-bit RGB pixel per transfer on the pixel channel and
// returns one processed pixel per transfer on the result channel, in order.
// It sustains one pixel per clock cycle while the result side is not stalled;
// a pixel passes through two register stages on its way to the result channel:
// an input register that holds the accepted pixel, and a result register that
// holds the processed pixel while it waits for the consumer. The arithmetic
// between them is a single combinational pass (one 16x8 multiply per channel
// at most). The mode and the gains are written through the configuration
// port; they must only be changed while no pixel is in flight.
// ----------------------------------------------------------------------------
module rgb_pixel_point_ops
    import rpo_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = RPO_GAIN_FRAC_BITS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    rpo_in_if.sink                     pixel,
    rpo_out_if.source                  result,
    input  logic                       cfg_we,
    input  logic [RPO_CFG_INDEX_W-1:0] cfg_index,
    input  logic [RPO_CFG_DATA_W-1:0]  cfg_data
);

    cfg_t   cfg;
    pixel_t in_pix;
    pixel_t ops_res;

    logic   s1_valid_reg;
    logic   s1_valid_next;
    pixel_t s1_pix_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    pixel_t out_pix_reg;

    logic   out_advance;
    logic   in_xfer;

    // Configuration registers.
    rpo_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign in_pix.red   = pixel.in_red;
    assign in_pix.green = pixel.in_green;
    assign in_pix.blue  = pixel.in_blue;

    // The result register can take a new pixel when it is empty or when its
    // current pixel leaves in this cycle. The input register can take a new
    // pixel when it is empty or when its pixel moves on to the result stage.
    // This lets a new pixel transfer in while a finished pixel still waits.
    assign out_advance = !out_valid_reg || result.ready;
    assign pixel.ready = !s1_valid_reg || out_advance;
    assign in_xfer     = pixel.valid && pixel.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pixel.ready)
            s1_valid_next = pixel.valid;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_advance)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load only on a transfer into their stage.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_pix_reg <= in_pix;
        if (out_advance && s1_valid_reg)
            out_pix_reg <= ops_res;
    end

    // Per-pixel arithmetic on the registered input pixel.
    rpo_pixel_ops #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_pixel_ops
    (
        .pix (s1_pix_reg),
        .cfg (cfg),
        .res (ops_res)
    );

    assign result.valid     = out_valid_reg;
    assign result.out_red   = out_pix_reg.red;
    assign result.out_green = out_pix_reg.green;
    assign result.out_blue  = out_pix_reg.blue;

endmodule

// ===== rtl/rpo_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rpo_cfg_regs: configuration register file
// Holds the mode, the three tint gains and the contrast factor. Writes to an
// index beyond the register list are ignored.
// ----------------------------------------------------------------------------
module rpo_cfg_regs
    import rpo_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [RPO_CFG_INDEX_W-1:0] cfg_index,
    input  logic [RPO_CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_OP_MODE:         cfg_next.op_mode         = op_mode_t'(cfg_data[1:0]);
                CFG_GAIN_RED:        cfg_next.gain_red        = cfg_data[RPO_GAIN_W-1:0];
                CFG_GAIN_GREEN:      cfg_next.gain_green      = cfg_data[RPO_GAIN_W-1:0];
                CFG_GAIN_BLUE:       cfg_next.gain_blue       = cfg_data[RPO_GAIN_W-1:0];
                CFG_CONTRAST_FACTOR: cfg_next.contrast_factor = cfg_data[RPO_GAIN_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_mode         <= OP_GRAY;
            cfg_reg.gain_red        <= RPO_GAIN_RESET;
            cfg_reg.gain_green      <= RPO_GAIN_RESET;
            cfg_reg.gain_blue       <= RPO_GAIN_RESET;
            cfg_reg.contrast_factor <= RPO_GAIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/rpo_pixel_ops.sv =====
// ----------------------------------------------------------------------------
// rpo_pixel_ops: per-pixel arithmetic
// Computes grayscale, tint, contrast or negative of one pixel in a single
// pass of combinational logic.
// ----------------------------------------------------------------------------
module rpo_pixel_ops
    import rpo_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = RPO_GAIN_FRAC_BITS_DEFAULT
)
(
    input  pixel_t pix,
    input  cfg_t   cfg,
    output pixel_t res
);

    localparam int TINT_PROD_W = RPO_CHAN_W + RPO_GAIN_W;
    localparam int CON_PROD_W  = RPO_GAIN_W + RPO_CHAN_W + 2;

    // Floor of c * gain, saturated at the channel maximum.
    function automatic logic [RPO_CHAN_W-1:0] tint_chan(
        input logic [RPO_CHAN_W-1:0] c,
        input logic [RPO_GAIN_W-1:0] gain
    );
        logic [TINT_PROD_W-1:0] prod;
        logic [TINT_PROD_W-1:0] q;
        begin
            prod = {{RPO_GAIN_W{1'b0}}, c} * {{RPO_CHAN_W{1'b0}}, gain};
            q    = prod >> GAIN_FRAC_BITS;
            if (q > TINT_PROD_W'(RPO_CHAN_MAX))
                tint_chan = RPO_CHAN_MAX;
            else
                tint_chan = q[RPO_CHAN_W-1:0];
        end
    endfunction

    // Factor times the distance from mid-gray, floored by an arithmetic shift,
    // moved back around mid-gray and clamped to the channel range.
    function automatic logic [RPO_CHAN_W-1:0] contrast_chan(
        input logic [RPO_CHAN_W-1:0] c,
        input logic [RPO_GAIN_W-1:0] factor
    );
        logic signed [RPO_CHAN_W:0]   d;
        logic signed [RPO_GAIN_W:0]   f;
        logic signed [CON_PROD_W-1:0] p;
        logic signed [CON_PROD_W-1:0] q;
        logic signed [CON_PROD_W-1:0] s;
        begin
            d = $signed({1'b0, c}) - $signed({1'b0, RPO_MID_GRAY});
            f = $signed({1'b0, factor});
            p = CON_PROD_W'(f) * CON_PROD_W'(d);
            q = p >>> GAIN_FRAC_BITS;
            s = q + $signed(CON_PROD_W'(RPO_MID_GRAY));
            if (s < 0)
                contrast_chan = '0;
            else if (s > $signed(CON_PROD_W'(RPO_CHAN_MAX)))
                contrast_chan = RPO_CHAN_MAX;
            else
                contrast_chan = s[RPO_CHAN_W-1:0];
        end
    endfunction

    logic [9:0]            chan_sum;
    logic [RPO_CHAN_W-1:0] mean;

    assign chan_sum = {2'b00, pix.red} + {2'b00, pix.green} + {2'b00, pix.blue};
    assign mean     = gray_mean(chan_sum);

    always_comb
    begin
        case (cfg.op_mode)
            OP_GRAY:
            begin
                res.red   = mean;
                res.green = mean;
                res.blue  = mean;
            end
            OP_TINT:
            begin
                res.red   = tint_chan(pix.red,   cfg.gain_red);
                res.green = tint_chan(pix.green, cfg.gain_green);
                res.blue  = tint_chan(pix.blue,  cfg.gain_blue);
            end
            OP_CONTRAST:
            begin
                res.red   = contrast_chan(pix.red,   cfg.contrast_factor);
                res.green = contrast_chan(pix.green, cfg.contrast_factor);
                res.blue  = contrast_chan(pix.blue,  cfg.contrast_factor);
            end
            default:
            begin
                res.red   = RPO_CHAN_MAX - pix.red;
                res.green = RPO_CHAN_MAX - pix.green;
                res.blue  = RPO_CHAN_MAX - pix.blue;
            end
        endcase
    end

endmodule

// ===== rtl/rpo_checker.sv =====
// ----------------------------------------------------------------------------
// rpo_checker: port-level assertions for rgb_pixel_point_ops
// Watches the pixel and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rpo_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue
);

    // The result channel is empty while reset is held.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // A stalled result holds its pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue))
        else $error("stalled result changed");

    // With the result stage empty the block always takes a new pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result stage");

    // A transferred pixel reaches the result channel, by way of the input register,
    // when the consumer is ready while the pixel waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("pixel did not reach result stage");

endmodule

bind rgb_pixel_point_ops rpo_checker u_rpo_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_red   (result.out_red),
    .out_green (result.out_green),
    .out_blue  (result.out_blue)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rgb_pixel_point_ops
// Streams RGB pixels through the block under every operating mode and a wide
// spread of gain and contrast settings, with random stalls on both channels.
// A scoreboard works out each expected pixel and compares it with the result.
// ----------------------------------------------------------------------------
module testbench
    import rpo_pkg::*;
();

    localparam int FRAC_BITS     = RPO_GAIN_FRAC_BITS_DEFAULT;
    localparam int RANDOM_PIXELS = 1700;
    // The last stretch of the random part runs with no idling on either side.
    localparam int QUIET_TAIL    = 150;
    // The limit is far above what the slowest correct run needs.
    localparam int CYCLE_LIMIT   = 200000;
    // Covers the two register stages inside the block, with room to catch stray results.
    localparam int SETTLE_CYCLES = 10;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [RPO_CFG_INDEX_W-1:0] cfg_index;
    logic [RPO_CFG_DATA_W-1:0]  cfg_data;

    // Enables the random idle bursts on both channels.
    bit                         idle_on;
    int unsigned                cycle_count;

    rpo_in_if  pixel_ch ();
    rpo_out_if result_ch ();

    rgb_pixel_point_ops #(
        .GAIN_FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the mode and gain registers, works
    // out the processed pixel for every accepted input transfer and checks
    // each result transfer against the oldest pixel still owed.
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        op_mode_t              mode;
        logic [RPO_GAIN_W-1:0] gain_red;
        logic [RPO_GAIN_W-1:0] gain_green;
        logic [RPO_GAIN_W-1:0] gain_blue;
        logic [RPO_GAIN_W-1:0] contrast_factor;
        pixel_t                owed_pixels[$];
        int                    mismatches;

        function new();
            mode            = OP_GRAY;
            gain_red        = RPO_GAIN_RESET;
            gain_green      = RPO_GAIN_RESET;
            gain_blue       = RPO_GAIN_RESET;
            contrast_factor = RPO_GAIN_RESET;
            mismatches      = 0;
        endfunction

        // Mirrors a register write. Values are cut to the register width, and
        // an index past the last register changes nothing.
        function void note_config(logic [RPO_CFG_INDEX_W-1:0] index,
                                  logic [RPO_CFG_DATA_W-1:0] data);
            case (index)
                CFG_OP_MODE:         mode            = op_mode_t'(data[1:0]);
                CFG_GAIN_RED:        gain_red        = data[RPO_GAIN_W-1:0];
                CFG_GAIN_GREEN:      gain_green      = data[RPO_GAIN_W-1:0];
                CFG_GAIN_BLUE:       gain_blue       = data[RPO_GAIN_W-1:0];
                CFG_CONTRAST_FACTOR: contrast_factor = data[RPO_GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact product, floored by the shift, saturated at full scale.
        function logic [RPO_CHAN_W-1:0] tint_level(logic [RPO_CHAN_W-1:0] c,
                                                   logic [RPO_GAIN_W-1:0] gain);
            longint scaled;
            scaled = (longint'(c) * longint'(gain)) >>> FRAC_BITS;
            return (scaled > longint'(RPO_CHAN_MAX)) ? RPO_CHAN_MAX : RPO_CHAN_W'(scaled);
        endfunction

        // The signed distance from mid-gray is scaled; the arithmetic shift
        // floors toward minus infinity, then the sum is clamped to 0..255.
        function logic [RPO_CHAN_W-1:0] contrast_level(logic [RPO_CHAN_W-1:0] c,
                                                       logic [RPO_GAIN_W-1:0] factor);
            longint stretched;
            stretched = longint'(factor) * (longint'(c) - longint'(RPO_MID_GRAY));
            stretched = (stretched >>> FRAC_BITS) + longint'(RPO_MID_GRAY);
            if (stretched < 0)
            begin
                stretched = 0;
            end
            if (stretched > longint'(RPO_CHAN_MAX))
            begin
                stretched = longint'(RPO_CHAN_MAX);
            end
            return RPO_CHAN_W'(stretched);
        endfunction

        function pixel_t process_pixel(pixel_t px);
            pixel_t      res;
            int unsigned mean;
            case (mode)
                OP_GRAY:
                begin
                    mean      = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
                    res.red   = RPO_CHAN_W'(mean);
                    res.green = RPO_CHAN_W'(mean);
                    res.blue  = RPO_CHAN_W'(mean);
                end
                OP_TINT:
                begin
                    res.red   = tint_level(px.red,   gain_red);
                    res.green = tint_level(px.green, gain_green);
                    res.blue  = tint_level(px.blue,  gain_blue);
                end
                OP_CONTRAST:
                begin
                    res.red   = contrast_level(px.red,   contrast_factor);
                    res.green = contrast_level(px.green, contrast_factor);
                    res.blue  = contrast_level(px.blue,  contrast_factor);
                end
                default:
                begin
                    res.red   = RPO_CHAN_MAX - px.red;
                    res.green = RPO_CHAN_MAX - px.green;
                    res.blue  = RPO_CHAN_MAX - px.blue;
                end
            endcase
            return res;
        endfunction

        function void note_pixel(pixel_t px);
            owed_pixels.push_back(process_pixel(px));
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(pixel_t got);
            pixel_t want;
            if (owed_pixels.size() == 0)
            begin
                report($sformatf("result %h arrived with no pixel owed", got));
                return;
            end
            want = owed_pixels.pop_front();
            if (got.red !== want.red)
            begin
                report($sformatf("red got %0d, want %0d", got.red, want.red));
            end
            if (got.green !== want.green)
            begin
                report($sformatf("green got %0d, want %0d", got.green, want.green));
            end
            if (got.blue !== want.blue)
            begin
                report($sformatf("blue got %0d, want %0d", got.blue, want.blue));
            end
        endtask

        task check_drained();
            if (owed_pixels.size() != 0)
            begin
                report($sformatf("%0d results never arrived", owed_pixels.size()));
            end
        endtask
    endclass

    pixel_scoreboard sb = new();

    // ------------------------------------------------------------------------
    // Clock and cycle limit.
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side. A transfer is sampled at the rising edge, before the block's
    // registers move, and ready is then chosen for the next cycle: either held
    // high or dropped for a random burst.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left      = 0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                sb.check_result({result_ch.out_red, result_ch.out_green, result_ch.out_blue});
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left      = $urandom_range(0, 3);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Each starts and ends at a rising edge. Valid is left high
    // after a transfer so that back-to-back pixels need no extra edge; only an
    // idle burst or a drain lowers it.
    // ------------------------------------------------------------------------
    task automatic send_pixel(pixel_t px);
        pixel_ch.valid    <= 1'b1;
        pixel_ch.in_red   <= px.red;
        pixel_ch.in_green <= px.green;
        pixel_ch.in_blue  <= px.blue;
        do
        begin
            @(posedge clk);
        end
        while (!pixel_ch.ready);
        sb.note_pixel(px);
    endtask

    task automatic idle_input(int cycles);
        pixel_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Holds back input until every owed result has been taken, which leaves
    // the block empty and safe for register writes.
    task automatic wait_drained();
        pixel_ch.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // The write lands at the next edge; the caller lowers the enable after
    // the last write of a series.
    task automatic write_register(logic [RPO_CFG_INDEX_W-1:0] index,
                                  logic [RPO_CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.note_config(index, data);
    endtask

    // Mode words carry random upper bits, which the block must drop.
    function automatic logic [RPO_CFG_DATA_W-1:0] mode_word(op_mode_t op);
        return {14'($urandom), op};
    endfunction

    // Gains and factors lean toward the edges of their range and toward
    // values near unity, where outputs are not simply saturated.
    function automatic logic [RPO_GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return RPO_GAIN_RESET;
            3:       return RPO_GAIN_W'($urandom_range(0, 511));
            4:       return RPO_GAIN_W'($urandom_range(0, 4095));
            default: return RPO_GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [RPO_CHAN_W-1:0] pick_channel();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return RPO_CHAN_MAX;
            2:       return RPO_MID_GRAY;
            3:       return RPO_CHAN_W'(RPO_MID_GRAY - 1);
            default: return RPO_CHAN_W'($urandom);
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        px.red   = pick_channel();
        px.green = pick_channel();
        px.blue  = pick_channel();
        return px;
    endfunction

    // Writes a fresh setting between segments. The mode is always written;
    // each gain only part of the time so that old values carry over, and now
    // and then a write goes to an index past the register list.
    task automatic random_setup();
        bit all_regs;
        wait_drained();
        all_regs = ($urandom_range(0, 2) == 0);
        write_register(CFG_OP_MODE, mode_word(op_mode_t'($urandom_range(0, 3))));
        if (all_regs || $urandom_range(0, 1) == 0)
        begin
            write_register(CFG_GAIN_RED, pick_gain());
        end
        if (all_regs || $urandom_range(0, 1) == 0)
        begin
            write_register(CFG_GAIN_GREEN, pick_gain());
        end
        if (all_regs || $urandom_range(0, 1) == 0)
        begin
            write_register(CFG_GAIN_BLUE, pick_gain());
        end
        if (all_regs || $urandom_range(0, 1) == 0)
        begin
            write_register(CFG_CONTRAST_FACTOR, pick_gain());
        end
        if ($urandom_range(0, 7) == 0)
        begin
            write_register(RPO_CFG_INDEX_W'($urandom_range(int'(CFG_CONTRAST_FACTOR) + 1,
                                                           (1 << RPO_CFG_INDEX_W) - 1)),
                           RPO_CFG_DATA_W'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed part: each mode at the corners of the channel range, with the
    // gain and factor extremes (zero, full scale, unity and double), the
    // grayscale truncation, and writes to the unused register indexes.
    // ------------------------------------------------------------------------
    task automatic run_directed();
        // Reset values: grayscale with unity gains.
        send_pixel('{red: 8'd0,   green: 8'd0,   blue: 8'd0});
        send_pixel('{red: 8'd255, green: 8'd255, blue: 8'd255});
        send_pixel('{red: 8'd255, green: 8'd255, blue: 8'd254});
        send_pixel('{red: 8'd1,   green: 8'd1,   blue: 8'd0});

        // Tint with a zero gain, a full-scale gain and a unity gain.
        wait_drained();
        write_register(CFG_OP_MODE, mode_word(OP_TINT));
        write_register(CFG_GAIN_RED, '0);
        write_register(CFG_GAIN_GREEN, '1);
        write_register(CFG_GAIN_BLUE, RPO_GAIN_RESET);
        cfg_we <= 1'b0;
        send_pixel('{red: 8'd255, green: 8'd255, blue: 8'd255});
        send_pixel('{red: 8'd0,   green: 8'd1,   blue: 8'd128});
        send_pixel('{red: 8'd1,   green: 8'd0,   blue: 8'd255});

        // Contrast with a zero factor: everything goes to mid-gray.
        wait_drained();
        write_register(CFG_OP_MODE, mode_word(OP_CONTRAST));
        write_register(CFG_CONTRAST_FACTOR, '0);
        cfg_we <= 1'b0;
        send_pixel('{red: 8'd0, green: 8'd128, blue: 8'd255});

        // Full-scale factor: both clamps, and the floor just below mid-gray.
        wait_drained();
        write_register(CFG_CONTRAST_FACTOR, '1);
        cfg_we <= 1'b0;
        send_pixel('{red: 8'd0,   green: 8'd127, blue: 8'd129});
        send_pixel('{red: 8'd255, green: 8'd128, blue: 8'd1});

        // A factor of two with even distances, then a fraction below one.
        wait_drained();
        write_register(CFG_CONTRAST_FACTOR, RPO_GAIN_RESET << 1);
        cfg_we <= 1'b0;
        send_pixel('{red: 8'd64, green: 8'd192, blue: 8'd100});
        wait_drained();
        write_register(CFG_CONTRAST_FACTOR, RPO_GAIN_W'(77));
        cfg_we <= 1'b0;
        send_pixel('{red: 8'd127, green: 8'd3, blue: 8'd250});

        // Writes past the register list must leave every register alone.
        wait_drained();
        for (int i = int'(CFG_CONTRAST_FACTOR) + 1; i < (1 << RPO_CFG_INDEX_W); i++)
        begin
            write_register(RPO_CFG_INDEX_W'(i), RPO_CFG_DATA_W'($urandom));
        end
        write_register(CFG_OP_MODE, mode_word(OP_NEGATIVE));
        cfg_we <= 1'b0;
        send_pixel('{red: 8'd0,   green: 8'd255, blue: 8'd85});
        send_pixel('{red: 8'd170, green: 8'd1,   blue: 8'd254});
    endtask

    // ------------------------------------------------------------------------
    // Random part: segments of random length, each under a fresh setting, with
    // idling switched on for most segments and off for some. The sender drains
    // the block before every segment, so it also pauses until every owed
    // result has come. The tail runs at full rate on both channels.
    // ------------------------------------------------------------------------
    task automatic run_random();
        int  sent;
        int  seg_len;
        bit  quiet;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            seg_len = $urandom_range(20, 90);
            quiet   = (sent >= RANDOM_PIXELS - QUIET_TAIL);
            random_setup();
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < seg_len && sent < RANDOM_PIXELS; k++)
            begin
                send_pixel(random_pixel());
                sent++;
                if (idle_on && $urandom_range(0, 4) == 0)
                begin
                    idle_input($urandom_range(1, 4));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed pixels, random pixels, final drain.
    // ------------------------------------------------------------------------
    initial
    begin
        cycle_count       <= 0;
        idle_on           = 1'b0;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_OP_MODE;
        cfg_data          <= '0;
        pixel_ch.valid    <= 1'b0;
        pixel_ch.in_red   <= '0;
        pixel_ch.in_green <= '0;
        pixel_ch.in_blue  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b1;
        run_directed();
        run_random();

        wait_drained();
        idle_on = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.check_drained();

        if (sb.mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
